>>> hw/rtl/nac_pkg.sv
// Shared types and constants for the neighbor address cache.
package nac_pkg;

    localparam int CACHE_ENTRIES_DEF = 16;
    localparam int ADDR_W            = 64;
    localparam int MAC_W             = 48;
    localparam int SLOT_W            = 4;
    localparam int OUTCOME_W         = 2;

    // Result code for the kind of write an insert performed.
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NONE   = 2'd0,
        OUT_UPDATE = 2'd1,
        OUT_FILL   = 2'd2,
        OUT_EVICT  = 2'd3
    } t_outcome;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESULT
    } t_state;

    // One stored entry.
    typedef struct packed {
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [MAC_W-1:0]  mac;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic write;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic accept;
        logic scan_done;
        logic is_insert;
        logic out_busy;
    } t_status;

endpackage

>>> hw/rtl/nac_ifs.sv
// Handshake channel interfaces for request and result items.
interface nac_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [nac_pkg::ADDR_W-1:0] addr_high;
    logic [nac_pkg::ADDR_W-1:0] addr_low;
    logic [nac_pkg::MAC_W-1:0]  mac_in;

    modport source (output valid, action, addr_high, addr_low, mac_in, input ready);
    modport sink   (input valid, action, addr_high, addr_low, mac_in, output ready);
endinterface

interface nac_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [nac_pkg::MAC_W-1:0]     mac_out;
    logic [nac_pkg::SLOT_W-1:0]    slot;
    logic [nac_pkg::OUTCOME_W-1:0] insert_outcome;

    modport source (output valid, found, mac_out, slot, insert_outcome, input ready);
    modport sink   (input valid, found, mac_out, slot, insert_outcome, output ready);
endinterface

>>> hw/rtl/nac_ctrl.sv
// Controller state machine that sequences scan, write and result delivery.
module nac_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nac_pkg::t_status i_sts,
    output nac_pkg::t_cmd    o_cmd
);
    import nac_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_sts.accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.is_insert ? ST_WRITE : ST_RESULT;
                end
            end
            ST_WRITE: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            ST_SCAN: begin
                o_cmd = '0;
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
            end
            ST_RESULT: begin
                o_cmd.out_load = !i_sts.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/nac_dpath.sv
// Datapath: entry memory, valid bits, scan pipeline and result register.
module nac_dpath #(
    parameter int CACHE_ENTRIES = nac_pkg::CACHE_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nac_pkg::t_cmd    i_cmd,
    output nac_pkg::t_status o_sts,
    nac_in_if.sink           i_item,
    nac_out_if.source        o_item
);
    import nac_pkg::*;

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

    // Entry storage and valid bits.
    t_entry                   r_mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] r_valid;

    // Request held for the length of the item.
    logic              r_action;
    logic [ADDR_W-1:0] r_key_hi;
    logic [ADDR_W-1:0] r_key_lo;
    logic [MAC_W-1:0]  r_key_mac;

    // Scan pipeline: read issue and compare stages.
    logic          r_issue;
    logic [IW-1:0] r_rd_idx;
    logic          r_cmp_vld;
    logic          r_cmp_last;
    logic [IW-1:0] r_cmp_idx;
    t_entry        r_rd_data;

    // Scan results.
    logic             r_hit;
    logic [IW-1:0]    r_hit_idx;
    logic [MAC_W-1:0] r_hit_mac;
    logic             r_free;
    logic [IW-1:0]    r_free_idx;

    // Result register.
    logic              r_out_valid;
    logic              r_found;
    logic [MAC_W-1:0]  r_mac_out;
    logic [SLOT_W-1:0] r_slot;
    t_outcome          r_outcome;

    logic                 w_accept;
    logic                 w_match;
    logic                 w_empty;
    logic [IW-1:0]        w_wr_idx;
    logic [IW-1:0]        w_res_idx;
    logic [IW+SLOT_W-1:0] w_slot_ext;
    t_outcome             w_outcome;

    assign i_item.ready = i_cmd.in_ready;
    assign w_accept     = i_item.valid && i_cmd.in_ready;

    // Compare stage: a valid entry with the same key, or an empty slot.
    assign w_match = r_cmp_vld && r_valid[r_cmp_idx]
                     && (r_rd_data.addr_high == r_key_hi)
                     && (r_rd_data.addr_low == r_key_lo);
    assign w_empty = r_cmp_vld && !r_valid[r_cmp_idx];

    // Insert target and its outcome code.
    always_comb begin
        if (r_hit) begin
            w_wr_idx  = r_hit_idx;
            w_outcome = OUT_UPDATE;
        end else if (r_free) begin
            w_wr_idx  = r_free_idx;
            w_outcome = OUT_FILL;
        end else begin
            w_wr_idx  = '0;
            w_outcome = OUT_EVICT;
        end
    end

    // Reported slot: the written slot on insert, the matching slot on lookup.
    assign w_res_idx  = r_action ? w_wr_idx : (r_hit ? r_hit_idx : '0);
    assign w_slot_ext = {{SLOT_W{1'b0}}, w_res_idx};

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action  <= i_item.action;
            r_key_hi  <= i_item.addr_high;
            r_key_lo  <= i_item.addr_low;
            r_key_mac <= i_item.mac_in;
        end
    end

    // Read issue: one entry per cycle from slot 0 upward.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue    <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_cmp_last <= 1'b0;
        end else begin
            r_cmp_vld  <= r_issue;
            r_cmp_last <= r_issue && (r_rd_idx == LAST_IDX);
            if (w_accept) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_rd_idx == LAST_IDX)) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_idx <= '0;
        end else if (r_issue) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        r_cmp_idx <= r_rd_idx;
    end

    // Entry memory with one write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[w_wr_idx] <= '{addr_high: r_key_hi, addr_low: r_key_lo, mac: r_key_mac};
        end
        if (r_issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    // Valid bits, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.write) begin
            r_valid[w_wr_idx] <= 1'b1;
        end
    end

    // Keep the lowest matching slot and the lowest empty slot.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else begin
            if (w_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
                r_hit_mac <= r_rd_data.mac;
            end
            if (w_empty && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
        end
    end

    // Result register: holds one item until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_item.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_found   <= !r_action && r_hit;
            r_mac_out <= (!r_action && r_hit) ? r_hit_mac : '0;
            r_slot    <= w_slot_ext[SLOT_W-1:0];
            r_outcome <= r_action ? w_outcome : OUT_NONE;
        end
    end

    assign o_item.valid          = r_out_valid;
    assign o_item.found          = r_found;
    assign o_item.mac_out        = r_mac_out;
    assign o_item.slot           = r_slot;
    assign o_item.insert_outcome = r_outcome;

    // Status to the controller.
    assign o_sts.accept    = w_accept;
    assign o_sts.scan_done = r_cmp_vld && r_cmp_last;
    assign o_sts.is_insert = r_action;
    assign o_sts.out_busy  = r_out_valid && !o_item.ready;

endmodule

>>> hw/rtl/neighbor_address_cache.sv
// Neighbor address cache: a fully associative table mapping IPv6 addresses
// to MAC addresses. Each item is a lookup or an insert and yields one result
// item. The block takes one item at a time: after acceptance it reads the
// entry memory one slot per cycle, through all CACHE_ENTRIES slots; an insert
// then writes its slot, and the result is loaded before the block returns to
// idle. The single read port of the entry memory sets the length of the scan.
// A finished result waits in an output register, and the next item is accepted
// meanwhile; if that result is still waiting when the next one finishes, the
// load stalls until the sink takes it.
// Valid bits clear at reset; no clearing pass is needed.
module neighbor_address_cache #(
    parameter int CACHE_ENTRIES = nac_pkg::CACHE_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nac_in_if.sink    i_item,
    nac_out_if.source o_item
);
    import nac_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    // Controller.
    nac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Datapath.
    nac_dpath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_item  (i_item),
        .o_item  (o_item)
    );

    // Only one item is in progress at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.accept |=> !w_cmd.in_ready)
        else $error("item accepted while another is in progress");

    // The scan never completes while the block is open for a new item or writing an entry.
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.scan_done |-> !w_cmd.in_ready && !w_cmd.write)
        else $error("scan completion outside of a scan");

    // A loaded result is presented on the next cycle.
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_item.valid)
        else $error("loaded result not presented");

endmodule

>>> tb/sv/neighbor_address_cache_test.sv
// Self-checking testbench for the neighbor address cache lookup and insert channel.
`timescale 1ns / 1ps

module neighbor_address_cache_test;
    import nac_pkg::*;

    localparam int ENTRIES    = CACHE_ENTRIES_DEF;
    localparam int KEY_POOL   = 24;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 40;

    // Operation codes of the request channel.
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    // One result item as the cache should produce it.
    typedef struct {
        logic              found;
        logic [MAC_W-1:0]  mac_out;
        logic [SLOT_W-1:0] slot;
        t_outcome          outcome;
    } t_reply;

    // Mirror of the address table plus the queue of replies still owed.
    class nac_scoreboard;
        bit                entry_used [ENTRIES];
        logic [ADDR_W-1:0] entry_high [ENTRIES];
        logic [ADDR_W-1:0] entry_low  [ENTRIES];
        logic [MAC_W-1:0]  entry_mac  [ENTRIES];
        t_reply            owed_replies[$];
        int                errors;

        function int pending();
            return owed_replies.size();
        endfunction

        task report(input string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        // Apply one accepted request to the table and queue its reply.
        function void note_request(input logic action, input logic [ADDR_W-1:0] hi,
                                   input logic [ADDR_W-1:0] lo,
                                   input logic [MAC_W-1:0] mac);
            t_reply r;
            int     hit;
            int     free_idx;
            int     i;
            hit      = -1;
            free_idx = -1;
            r.found   = 1'b0;
            r.mac_out = '0;
            r.slot    = '0;
            r.outcome = OUT_NONE;
            for (i = ENTRIES - 1; i >= 0; i--) begin
                if (entry_used[i] && entry_high[i] == hi && entry_low[i] == lo) hit = i;
                if (!entry_used[i]) free_idx = i;
            end
            if (action == ACT_LOOKUP) begin
                if (hit >= 0) begin
                    r.found   = 1'b1;
                    r.mac_out = entry_mac[hit];
                    r.slot    = SLOT_W'(hit);
                end
            end else if (hit >= 0) begin
                entry_mac[hit] = mac;
                r.slot    = SLOT_W'(hit);
                r.outcome = OUT_UPDATE;
            end else begin
                // No match: take the lowest free slot, or evict slot 0 when full.
                if (free_idx >= 0) begin
                    r.outcome = OUT_FILL;
                end else begin
                    free_idx  = 0;
                    r.outcome = OUT_EVICT;
                end
                entry_used[free_idx] = 1'b1;
                entry_high[free_idx] = hi;
                entry_low[free_idx]  = lo;
                entry_mac[free_idx]  = mac;
                r.slot = SLOT_W'(free_idx);
            end
            owed_replies.push_back(r);
        endfunction

        // Compare one accepted result item with the oldest owed reply.
        task check_reply(input logic found, input logic [MAC_W-1:0] mac_out,
                         input logic [SLOT_W-1:0] slot,
                         input logic [OUTCOME_W-1:0] outcome);
            t_reply r;
            if (owed_replies.size() == 0) begin
                report("result item arrived with no request outstanding");
            end else begin
                r = owed_replies.pop_front();
                if (found !== r.found)
                    report($sformatf("found %b, expected %b", found, r.found));
                if (mac_out !== r.mac_out)
                    report($sformatf("mac_out %h, expected %h", mac_out, r.mac_out));
                if (slot !== r.slot)
                    report($sformatf("slot %0d, expected %0d", slot, r.slot));
                if (outcome !== r.outcome)
                    report($sformatf("insert_outcome %b, expected %s", outcome,
                                     r.outcome.name()));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    nac_in_if  req_ch ();
    nac_out_if rsp_ch ();

    neighbor_address_cache dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (req_ch),
        .o_item  (rsp_ch)
    );

    nac_scoreboard sb = new;

    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;

    logic [ADDR_W-1:0] pool_high [KEY_POOL];
    logic [ADDR_W-1:0] pool_low  [KEY_POOL];

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side: randomly stall, and check every accepted item.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_reply(rsp_ch.found, rsp_ch.mac_out, rsp_ch.slot, rsp_ch.insert_outcome);
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] timeout: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one request, with random idle cycles ahead of it, until accepted.
    task automatic send_request(input logic action, input logic [ADDR_W-1:0] hi,
                                input logic [ADDR_W-1:0] lo, input logic [MAC_W-1:0] mac);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.action    = action;
        req_ch.addr_high = hi;
        req_ch.addr_low  = lo;
        req_ch.mac_in    = mac;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(action, hi, lo, mac);
    endtask

    // Stop sending and wait until every owed reply has come back.
    task automatic drain_replies();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Random traffic over the key pool, with near misses and fresh keys.
    task automatic run_random(input int count);
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic [63:0]       wide;
        logic [MAC_W-1:0]  mac;
        int                pick;
        int                bitpos;
        int                n;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            hi   = pool_high[$urandom_range(0, KEY_POOL - 1)];
            lo   = pool_low[$urandom_range(0, KEY_POOL - 1)];
            if (pick < 80) begin
                bitpos = $urandom_range(0, KEY_POOL - 1);
                hi     = pool_high[bitpos];
                lo     = pool_low[bitpos];
            end else begin
                if (pick < 90) begin
                    // Near miss: one bit flipped in a key built from two pool halves.
                    bitpos = $urandom_range(0, 2 * ADDR_W - 1);
                    if (bitpos < ADDR_W) hi[bitpos] = ~hi[bitpos];
                    else lo[bitpos - ADDR_W] = ~lo[bitpos - ADDR_W];
                end else begin
                    hi = {$urandom, $urandom};
                    lo = {$urandom, $urandom};
                end
                if ($urandom_range(0, 1)) begin
                    bitpos            = $urandom_range(ENTRIES, KEY_POOL - 1);
                    pool_high[bitpos] = hi;
                    pool_low[bitpos]  = lo;
                end
            end
            wide = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0: mac = '0;
                1: mac = '1;
                default: mac = wide[MAC_W-1:0];
            endcase
            send_request($urandom_range(0, 1) ? ACT_INSERT : ACT_LOOKUP, hi, lo, mac);
        end
    endtask

    // Main sequence: reset, directed cases, then three random phases.
    initial begin
        logic [ADDR_W-1:0] shared_high;
        logic [ADDR_W-1:0] shared_low;
        logic [63:0]       wide;
        int                i;

        idle_cycles      = 0;
        send_idle_pct    = 31;
        recv_stall_pct   = 75;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.action    = ACT_LOOKUP;
        req_ch.addr_high = '0;
        req_ch.addr_low  = '0;
        req_ch.mac_in    = '0;

        // Key pool: some keys share one half so both halves must be compared.
        shared_high = {$urandom, $urandom};
        shared_low  = {$urandom, $urandom};
        for (i = 0; i < KEY_POOL; i++) begin
            pool_high[i] = (i % 3 == 0) ? shared_high : {$urandom, $urandom};
            pool_low[i]  = (i % 3 == 1) ? shared_low  : {$urandom, $urandom};
        end
        pool_high[0] = '0;  pool_low[0] = '0;
        pool_high[1] = '1;  pool_low[1] = '1;
        pool_high[2] = '0;  pool_low[2] = '1;
        pool_high[3] = '1;  pool_low[3] = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Lookup on the empty table misses.
        send_request(ACT_LOOKUP, pool_high[0], pool_low[0], '1);
        // Fill every slot, with the extreme MAC values first.
        for (i = 0; i < ENTRIES; i++) begin
            wide = {$urandom, $urandom};
            send_request(ACT_INSERT, pool_high[i], pool_low[i],
                         (i == 0) ? '0 : (i == 1) ? '1 : wide[MAC_W-1:0]);
        end
        // Full table: a new key evicts slot 0.
        send_request(ACT_INSERT, pool_high[ENTRIES], pool_low[ENTRIES], '1);
        send_request(ACT_LOOKUP, pool_high[0], pool_low[0], '0);
        send_request(ACT_LOOKUP, pool_high[ENTRIES], pool_low[ENTRIES], '0);
        send_request(ACT_LOOKUP, pool_high[ENTRIES-1], pool_low[ENTRIES-1], '0);
        // Update of an existing key, then read it back.
        send_request(ACT_INSERT, pool_high[1], pool_low[1], '0);
        send_request(ACT_LOOKUP, pool_high[1], pool_low[1], '1);
        // A key one bit off a stored key must miss.
        send_request(ACT_LOOKUP, pool_high[3], pool_low[3] ^ 64'd1, '0);
        send_request(ACT_LOOKUP, pool_high[2], pool_low[2], '1);

        run_random(250);
        drain_replies();

        send_idle_pct  = 75;
        recv_stall_pct = 31;
        run_random(250);
        drain_replies();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(250);
        drain_replies();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> neighbor_address_cache.f
hw/rtl/nac_pkg.sv
hw/rtl/nac_ifs.sv
hw/rtl/nac_ctrl.sv
hw/rtl/nac_dpath.sv
hw/rtl/neighbor_address_cache.sv
tb/sv/neighbor_address_cache_test.sv
